// File: hw/rtl/nnfs_pkg.sv
// shared types, constants and register map of the nearest-neighbor frame scaler
package nnfs_pkg;

   // default sizes, handed to the top level parameters
   localparam int MAX_SRC_W_DEF   = 128;
   localparam int MAX_SRC_H_DEF   = 128;
   localparam int MAX_DST_DIM_DEF = 4095;

   // fixed-point and field widths
   localparam int FRAC_BITS  = 16;
   localparam int ACC_W      = 32;
   localparam int SRC_REG_W  = 8;
   localparam int DST_REG_W  = 12;
   localparam int PIX_W      = 24;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [7:0] ALPHA = 8'hFF;

   // commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_SRC_WIDTH  = 2'd0,
      REG_SRC_HEIGHT = 2'd1,
      REG_DST_WIDTH  = 2'd2,
      REG_DST_HEIGHT = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_word;
      logic        row_end;
      logic        frame_end;
   } rsp_type;

endpackage

// File: hw/rtl/nearest_neighbor_frame_scaler.sv
// top level of the nearest-neighbor stretch-to-fill frame scaler
//
// commands come in on start/req_data and are taken when start is high and
// busy is low. a load command writes one rgb888 source pixel into the frame
// store at the next raster position; it gives no result and the next command
// may follow in the next cycle. an emit command returns the next destination
// pixel as argb (alpha 0xff) with row and frame end flags on rsp_data, marked
// by rsp_valid for one cycle, in the cycle after its store read. the receiver
// cannot stall, so every result must be taken when it is shown.
// the first emit of a destination frame runs both 16.16 step divisions on a
// pair of restoring dividers, one quotient bit per cycle: busy stays high
// until both quotients are ready and the result follows after that. while
// busy is low, all other commands run at one per cycle, limited by the single
// port of the frame store, which a load writes and an emit reads.
// sizes are set through the apb port at byte addresses 0, 4, 8 and 12 and
// must only change while no command is in flight.
// reset clears the sizes to 1, the load position, the raster counters and
// the steps; the frame store is not cleared and holds garbage until loaded.
module nearest_neighbor_frame_scaler import nnfs_pkg::*; #(
   parameter int MAX_SRC_W   = MAX_SRC_W_DEF,
   parameter int MAX_SRC_H   = MAX_SRC_H_DEF,
   parameter int MAX_DST_DIM = MAX_DST_DIM_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   input  req_type               req_data,
   output logic                  busy,
   // result channel
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // size of the clamped dimensions
   localparam int SW_W    = $clog2(MAX_SRC_W + 1);
   localparam int SH_W    = $clog2(MAX_SRC_H + 1);
   localparam int DW_W    = $clog2(MAX_DST_DIM + 1);
   localparam int SRC_D_W = (SW_W > SH_W) ? SW_W : SH_W;
   // step quotient width, same for both axes so the dividers finish together
   localparam int DVD_W   = SRC_D_W + FRAC_BITS;
   localparam int DEPTH   = MAX_SRC_W * MAX_SRC_H;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W  = SW_W + SH_W;
   localparam int CRD_W   = ACC_W - FRAC_BITS;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DIV  = 2'b10
   } state_type;

   state_type         state_ff, state_in;

   // clamped sizes from the register bank
   logic [SW_W-1:0]   src_w;
   logic [SH_W-1:0]   src_h;
   logic [DW_W-1:0]   dst_w;
   logic [DW_W-1:0]   dst_h;

   // raster state
   logic [ADDR_W-1:0] load_idx_ff, load_idx_in;
   logic [DW_W-1:0]   col_cnt_ff, col_cnt_in;
   logic [DW_W-1:0]   row_cnt_ff, row_cnt_in;
   logic [ACC_W-1:0]  col_acc_ff, col_acc_in;
   logic [ACC_W-1:0]  row_acc_ff, row_acc_in;
   logic [DVD_W-1:0]  col_step_ff, col_step_in;
   logic [DVD_W-1:0]  row_step_ff, row_step_in;

   // result registers
   logic              rsp_valid_ff;
   logic              row_end_ff, row_end_in;
   logic              frame_end_ff, frame_end_in;

   // handshake decode
   logic              accept;
   logic              is_emit;
   logic              frame_start;
   logic              div_start;
   logic              emit_go;
   logic              ram_we;

   // dividers
   logic [DVD_W-1:0]  col_quo, row_quo;
   logic              col_done, row_done;
   logic [DVD_W-1:0]  col_step_sel, row_step_sel;

   // address generation
   logic [PROD_W-1:0] pix_count;
   logic [ADDR_W-1:0] load_pos;
   logic [ADDR_W:0]   load_next;
   logic [CRD_W-1:0]  col_crd, row_crd;
   logic [SW_W-1:0]   src_x;
   logic [SH_W-1:0]   src_y;
   logic [PROD_W-1:0] emit_lin;
   logic [ADDR_W-1:0] ram_addr;
   logic [PIX_W-1:0]  ram_rdata;
   logic              row_end, frame_end;

   nnfs_csr #(
      .MAX_SRC_W  (MAX_SRC_W),
      .MAX_SRC_H  (MAX_SRC_H),
      .MAX_DST_DIM(MAX_DST_DIM)
   ) u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .src_w  (src_w),
      .src_h  (src_h),
      .dst_w  (dst_w),
      .dst_h  (dst_h)
   );

   // step = (source size << 16) / destination size, per axis
   nnfs_div #(
      .DVD_W(DVD_W),
      .DVS_W(DW_W)
   ) u_col_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend({SRC_D_W'(src_w), FRAC_BITS'(0)}),
      .divisor (dst_w),
      .quotient(col_quo),
      .done    (col_done)
   );

   nnfs_div #(
      .DVD_W(DVD_W),
      .DVS_W(DW_W)
   ) u_row_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend({SRC_D_W'(src_h), FRAC_BITS'(0)}),
      .divisor (dst_h),
      .quotient(row_quo),
      .done    (row_done)
   );

   // command decode: a frame-start emit waits for the steps, others go now
   assign busy        = (state_ff == ST_DIV);
   assign accept      = start & ~busy;
   assign is_emit     = (req_data.cmd == CMD_EMIT);
   assign frame_start = (col_cnt_ff == '0) && (row_cnt_ff == '0);
   assign div_start   = accept & is_emit & frame_start;
   assign emit_go     = (accept & is_emit & ~frame_start) | (busy & col_done);
   assign ram_we      = accept & (req_data.cmd == CMD_LOAD);

   // fresh quotients are used on the cycle they land
   assign col_step_sel = col_done ? col_quo : col_step_ff;
   assign row_step_sel = row_done ? row_quo : row_step_ff;

   // load position wraps at the current source pixel count
   assign pix_count = PROD_W'(src_w) * PROD_W'(src_h);
   assign load_pos  = (32'(load_idx_ff) >= 32'(pix_count)) ? '0 : load_idx_ff;
   assign load_next = {1'b0, load_pos} + 1'b1;

   // source coordinate is the integer part of the accumulator, clamped
   assign col_crd  = col_acc_ff[ACC_W-1:FRAC_BITS];
   assign row_crd  = row_acc_ff[ACC_W-1:FRAC_BITS];
   assign src_x    = (32'(col_crd) >= 32'(src_w)) ? src_w - SW_W'(1) : SW_W'(col_crd);
   assign src_y    = (32'(row_crd) >= 32'(src_h)) ? src_h - SH_W'(1) : SH_W'(row_crd);
   assign emit_lin = PROD_W'(src_y) * PROD_W'(src_w) + PROD_W'(src_x);
   assign ram_addr = ram_we ? load_pos : ADDR_W'(emit_lin);

   // row and frame end, checked against the live destination size
   assign row_end   = (32'(col_cnt_ff) + 32'd1) >= 32'(dst_w);
   assign frame_end = row_end && ((32'(row_cnt_ff) + 32'd1) >= 32'(dst_h));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (div_start) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (col_done) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      load_idx_in  = load_idx_ff;
      col_cnt_in   = col_cnt_ff;
      row_cnt_in   = row_cnt_ff;
      col_acc_in   = col_acc_ff;
      row_acc_in   = row_acc_ff;
      col_step_in  = col_step_ff;
      row_step_in  = row_step_ff;
      row_end_in   = row_end_ff;
      frame_end_in = frame_end_ff;

      if (ram_we) begin
         load_idx_in = (32'(load_next) >= 32'(pix_count)) ? '0 : ADDR_W'(load_next);
      end

      // new frame: accumulators restart at the origin
      if (div_start) begin
         col_acc_in = '0;
         row_acc_in = '0;
      end

      if (busy && col_done) begin
         col_step_in = col_quo;
         row_step_in = row_quo;
      end

      if (emit_go) begin
         row_end_in   = row_end;
         frame_end_in = frame_end;
         if (!row_end) begin
            col_cnt_in = col_cnt_ff + 1'b1;
            col_acc_in = col_acc_ff + ACC_W'(col_step_sel);
         end else begin
            col_cnt_in = '0;
            col_acc_in = '0;
            if (!frame_end) begin
               row_cnt_in = row_cnt_ff + 1'b1;
               row_acc_in = row_acc_ff + ACC_W'(row_step_sel);
            end else begin
               row_cnt_in = '0;
               row_acc_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_idx_ff  <= '0;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         col_acc_ff   <= '0;
         row_acc_ff   <= '0;
         col_step_ff  <= '0;
         row_step_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_idx_ff  <= load_idx_in;
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         col_acc_ff   <= col_acc_in;
         row_acc_ff   <= row_acc_in;
         col_step_ff  <= col_step_in;
         row_step_ff  <= row_step_in;
         rsp_valid_ff <= emit_go;
      end
      row_end_ff   <= row_end_in;
      frame_end_ff <= frame_end_in;
   end

   // frame store: loads write, emits read, never both in one cycle
   nnfs_ram #(
      .WIDTH(PIX_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata({req_data.red, req_data.green, req_data.blue}),
      .rdata(ram_rdata)
   );

   // read data lines up with the registered flags in the cycle after the read
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.pixel_word = {ALPHA, ram_rdata};
   assign rsp_data.row_end    = row_end_ff;
   assign rsp_data.frame_end  = frame_end_ff;

`ifndef ASSERT_OFF
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while steps are being computed");

   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.row_end)
      else $error("frame end without row end");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> (col_cnt_ff == '0) && (row_cnt_ff == '0))
      else $error("raster counters not cleared after frame end");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> $past(col_done))
      else $error("left step computation without a quotient");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      col_done == row_done)
      else $error("column and row dividers out of step");
`endif

endmodule

// File: hw/rtl/nnfs_ram.sv
// generic single-port ram with registered read
module nnfs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/nnfs_div.sv
// restoring divider, one quotient bit per cycle
module nnfs_div #(
   parameter int DVD_W = 24,
   parameter int DVS_W = 12,
   localparam int CNT_W = $clog2(DVD_W + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output logic             done
);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(DVD_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// File: hw/rtl/nnfs_csr.sv
// apb register bank holding source and destination sizes, clamped for use
module nnfs_csr import nnfs_pkg::*; #(
   parameter int MAX_SRC_W   = MAX_SRC_W_DEF,
   parameter int MAX_SRC_H   = MAX_SRC_H_DEF,
   parameter int MAX_DST_DIM = MAX_DST_DIM_DEF,
   localparam int SW_W = $clog2(MAX_SRC_W + 1),
   localparam int SH_W = $clog2(MAX_SRC_H + 1),
   localparam int DW_W = $clog2(MAX_DST_DIM + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [SW_W-1:0]       src_w,
   output logic [SH_W-1:0]       src_h,
   output logic [DW_W-1:0]       dst_w,
   output logic [DW_W-1:0]       dst_h
);

   logic [SRC_REG_W-1:0] src_width_ff, src_width_in;
   logic [SRC_REG_W-1:0] src_height_ff, src_height_in;
   logic [DST_REG_W-1:0] dst_width_ff, dst_width_in;
   logic [DST_REG_W-1:0] dst_height_ff, dst_height_in;
   logic                 wr_en;
   reg_idx_type          idx;

   // zero reads as one, anything above the maximum as the maximum
   function automatic logic [31:0] clamp_dim(logic [31:0] v, logic [31:0] maxv);
      logic [31:0] r;
      r = v;
      if (v == 32'd0) begin
         r = 32'd1;
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

   assign wr_en  = psel & penable & pwrite;
   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign pready = 1'b1;

   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      dst_width_in  = dst_width_ff;
      dst_height_in = dst_height_ff;
      prdata        = '0;
      case (idx)
         REG_SRC_WIDTH: begin
            prdata = CSR_DATA_W'(src_width_ff);
            if (wr_en) src_width_in = pwdata[SRC_REG_W-1:0];
         end
         REG_SRC_HEIGHT: begin
            prdata = CSR_DATA_W'(src_height_ff);
            if (wr_en) src_height_in = pwdata[SRC_REG_W-1:0];
         end
         REG_DST_WIDTH: begin
            prdata = CSR_DATA_W'(dst_width_ff);
            if (wr_en) dst_width_in = pwdata[DST_REG_W-1:0];
         end
         REG_DST_HEIGHT: begin
            prdata = CSR_DATA_W'(dst_height_ff);
            if (wr_en) dst_height_in = pwdata[DST_REG_W-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_REG_W'(1);
         src_height_ff <= SRC_REG_W'(1);
         dst_width_ff  <= DST_REG_W'(1);
         dst_height_ff <= DST_REG_W'(1);
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         dst_width_ff  <= dst_width_in;
         dst_height_ff <= dst_height_in;
      end
   end

   assign src_w = SW_W'(clamp_dim(32'(src_width_ff), 32'(MAX_SRC_W)));
   assign src_h = SH_W'(clamp_dim(32'(src_height_ff), 32'(MAX_SRC_H)));
   assign dst_w = DW_W'(clamp_dim(32'(dst_width_ff), 32'(MAX_DST_DIM)));
   assign dst_h = DW_W'(clamp_dim(32'(dst_height_ff), 32'(MAX_DST_DIM)));

endmodule

// File: tb/nearest_neighbor_frame_scaler_tb.sv
// self-checking testbench for the nearest-neighbor stretch-to-fill frame scaler
module nearest_neighbor_frame_scaler_tb;
   import nnfs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // the frame store holds the largest source frame
   localparam int STORE_DEPTH = MAX_SRC_W_DEF * MAX_SRC_H_DEF;
   // the frame-start divide keeps busy high until the steps are ready, so this
   // covers a command still in flight after the last pixel came back
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 32;
   localparam req_type EMIT_REQ = '{CMD_EMIT, 8'h00, 8'h00, 8'h00};

   // dut inputs, all driven to known values from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   req_type req_data = '0;
   logic busy;
   logic rsp_valid;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   // scaler state as the testbench sees it
   logic [SRC_REG_W-1:0] src_w_reg = SRC_REG_W'(1);
   logic [SRC_REG_W-1:0] src_h_reg = SRC_REG_W'(1);
   logic [DST_REG_W-1:0] dst_w_reg = DST_REG_W'(1);
   logic [DST_REG_W-1:0] dst_h_reg = DST_REG_W'(1);
   logic [PIX_W-1:0] source_pixels [STORE_DEPTH];
   bit pixel_loaded [STORE_DEPTH];
   int unsigned load_pos = 0;
   int unsigned out_col = 0;
   int unsigned out_row = 0;
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   int unsigned col_inc = 0;
   int unsigned row_inc = 0;

   // pixels predicted but not yet returned, oldest first
   rsp_type expected_pixels [$];
   rsp_type oldest_pixel;
   int pixel_errors = 0;
   int pixels_checked = 0;
   int items_sent = 0;
   int size_settings = 0;

   nearest_neighbor_frame_scaler DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #10 clock = ~clock;

   // a zero size acts as 1, anything above the maximum acts as the maximum
   function automatic int unsigned eff_dim(input int unsigned value, input int unsigned maxv);
      if (value == 0) return 1;
      if (value > maxv) return maxv;
      return value;
   endfunction

   // store address the next emit reads, clamped to the current source size
   function automatic int unsigned fetch_addr();
      int unsigned sw, sh, sx, sy;
      sw = eff_dim(32'(src_w_reg), MAX_SRC_W_DEF);
      sh = eff_dim(32'(src_h_reg), MAX_SRC_H_DEF);
      sx = col_pos >> FRAC_BITS;
      sy = row_pos >> FRAC_BITS;
      if (sx >= sw) sx = sw - 1;
      if (sy >= sh) sy = sh - 1;
      return (sy * sw + sx) % STORE_DEPTH;
   endfunction

   // load: write at the raster position, wrapping at the source pixel count
   function automatic void store_source_pixel(input req_type item);
      int unsigned count;
      count = eff_dim(32'(src_w_reg), MAX_SRC_W_DEF) * eff_dim(32'(src_h_reg), MAX_SRC_H_DEF);
      // the source may have shrunk below the load position
      if (load_pos >= count) load_pos = 0;
      source_pixels[load_pos] = {item.red, item.green, item.blue};
      pixel_loaded[load_pos] = 1'b1;
      load_pos++;
      if (load_pos >= count) load_pos = 0;
   endfunction

   // emit: next destination pixel and its row and frame flags
   function automatic rsp_type predict_pixel();
      int unsigned sw, sh, dw, dh;
      rsp_type px;
      sw = eff_dim(32'(src_w_reg), MAX_SRC_W_DEF);
      sh = eff_dim(32'(src_h_reg), MAX_SRC_H_DEF);
      dw = eff_dim(32'(dst_w_reg), MAX_DST_DIM_DEF);
      dh = eff_dim(32'(dst_h_reg), MAX_DST_DIM_DEF);
      // steps are latched only at the start of a destination frame
      if (out_col == 0 && out_row == 0) begin
         col_inc = (sw << FRAC_BITS) / dw;
         row_inc = (sh << FRAC_BITS) / dh;
         col_pos = 0;
         row_pos = 0;
      end
      px.pixel_word = {ALPHA, source_pixels[fetch_addr()]};
      // compare against the current size, so a shrink mid-frame ends the row
      px.row_end = (out_col + 1 >= dw);
      px.frame_end = px.row_end && (out_row + 1 >= dh);
      if (!px.row_end) begin
         out_col++;
         col_pos += col_inc;
      end else begin
         out_col = 0;
         col_pos = 0;
         if (!px.frame_end) begin
            out_row++;
            row_pos += row_inc;
         end else begin
            out_row = 0;
            row_pos = 0;
         end
      end
      return px;
   endfunction

   // one command transfer; start stays high so back-to-back commands need no gap
   task automatic send_item(input req_type item);
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      // taken at this edge
      if (item.cmd == CMD_EMIT) begin
         expected_pixels.push_back(predict_pixel());
      end else begin
         store_source_pixel(item);
      end
      items_sent++;
   endtask

   task automatic sender_gap(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold off until every pixel is back and a trailing load has finished
   task automatic settle_block();
      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write followed by a read back; unused upper data bits are random
   task automatic write_size(input reg_idx_type idx, input int unsigned value);
      logic [CSR_DATA_W-1:0] field_mask;
      logic [CSR_DATA_W-1:0] wdata;
      field_mask = (idx == REG_SRC_WIDTH || idx == REG_SRC_HEIGHT) ? 32'h0000_00FF
                                                                    : 32'h0000_0FFF;
      wdata = ($urandom() & ~field_mask) | (value & field_mask);
      // write: setup then access
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_SRC_WIDTH: src_w_reg = wdata[SRC_REG_W-1:0];
         REG_SRC_HEIGHT: src_h_reg = wdata[SRC_REG_W-1:0];
         REG_DST_WIDTH: dst_w_reg = wdata[DST_REG_W-1:0];
         REG_DST_HEIGHT: dst_h_reg = wdata[DST_REG_W-1:0];
         default: begin
         end
      endcase
      // read back: setup then access
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== (wdata & field_mask)) begin
         $display("%0t: register %s read back expected %h actual %h",
                  $time, idx.name(), wdata & field_mask, prdata);
         pixel_errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      // one idle cycle before the next register transfer
      @(posedge clock);
   endtask

   task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                            input int unsigned dw, input int unsigned dh);
      write_size(REG_SRC_WIDTH, sw);
      write_size(REG_SRC_HEIGHT, sh);
      write_size(REG_DST_WIDTH, dw);
      write_size(REG_DST_HEIGHT, dh);
      size_settings++;
   endtask

   // random command; an emit that would hit a never-loaded pixel becomes a load
   function automatic req_type random_item(input int emit_pct);
      req_type item;
      item.cmd = ($urandom_range(0, 99) < emit_pct) ? CMD_EMIT : CMD_LOAD;
      item.red = 8'($urandom_range(0, 255));
      item.green = 8'($urandom_range(0, 255));
      item.blue = 8'($urandom_range(0, 255));
      if (item.cmd == CMD_EMIT && !pixel_loaded[fetch_addr()]) item.cmd = CMD_LOAD;
      return item;
   endfunction

   // every register at zero, its field maximum and back to one
   task automatic test_register_access();
      settle_block();
      set_sizes(0, 0, 0, 0);
      set_sizes(8'hFF, 8'hFF, 12'hFFF, 12'hFFF);
      set_sizes(1, 1, 1, 1);
   endtask

   // 2x2 source stretched to 3x2, extreme and alternating colors
   task automatic test_upscale_frame();
      settle_block();
      set_sizes(2, 2, 3, 2);
      send_item('{CMD_LOAD, 8'hFF, 8'hFF, 8'hFF});
      send_item('{CMD_LOAD, 8'h00, 8'h00, 8'h00});
      send_item('{CMD_LOAD, 8'hAA, 8'h55, 8'hAA});
      send_item('{CMD_LOAD, 8'h55, 8'hAA, 8'h55});
      repeat (6) send_item(EMIT_REQ);
   endtask

   // a 1x1 destination ends row and frame on every pixel
   task automatic test_single_pixel_frame();
      settle_block();
      set_sizes(2, 2, 1, 1);
      send_item(EMIT_REQ);
   endtask

   // shrink the source below the load position, next load restarts at zero
   task automatic test_load_wrap_after_shrink();
      settle_block();
      set_sizes(3, 1, 1, 1);
      send_item('{CMD_LOAD, 8'h12, 8'h34, 8'h56});
      send_item('{CMD_LOAD, 8'h9A, 8'hBC, 8'hDE});
      settle_block();
      set_sizes(1, 1, 1, 1);
      send_item('{CMD_LOAD, 8'h0F, 8'hF0, 8'h3C});
      send_item(EMIT_REQ);
   endtask

   // narrow the destination partway through a row, steps stay latched
   task automatic test_width_change_mid_frame();
      settle_block();
      set_sizes(2, 2, 4, 1);
      repeat (2) send_item(EMIT_REQ);
      settle_block();
      write_size(REG_DST_WIDTH, 2);
      send_item(EMIT_REQ);
   endtask

   // zero and over-maximum sizes, step division with the clamped source;
   // the full clamped source row is loaded before it is sampled
   task automatic test_out_of_range_sizes();
      settle_block();
      set_sizes(0, 200, 0, 0);
      send_item(EMIT_REQ);
      settle_block();
      set_sizes(8'hFF, 0, 3, 0);
      repeat (MAX_SRC_W_DEF) send_item(random_item(0));
      repeat (3) send_item(EMIT_REQ);
   endtask

   // random sizes per phase, mostly small, with the extremes forced early
   task automatic test_random_traffic();
      int idle_pct;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         // sender idle pattern rotates: none, heavy, none, light
         idle_pct = (p % 4 == 1) ? 64 : (p % 4 == 3) ? 32 : 0;
         settle_block();
         if (p == 0) begin
            set_sizes(8'hFF, 2, 12'hFFF, 3);
         end else if (p == 1) begin
            set_sizes(MAX_SRC_W_DEF, MAX_SRC_H_DEF, 2, 1);
         end else begin
            set_sizes(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6),
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(1, 9),
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7));
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
               sender_gap($urandom_range(1, 6));
            end
            // once, drain everything in the middle of a phase
            if (p == 2 && i == PHASE_ITEMS / 2) settle_block();
            send_item(random_item(60));
         end
      end
   endtask

   // result checker: the receiver cannot stall, take every strobed pixel
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: pixel with nothing expected, actual %h row_end %b frame_end %b",
                     $time, rsp_data.pixel_word, rsp_data.row_end, rsp_data.frame_end);
            pixel_errors++;
         end else begin
            oldest_pixel = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_data.pixel_word !== oldest_pixel.pixel_word ||
                rsp_data.row_end !== oldest_pixel.row_end ||
                rsp_data.frame_end !== oldest_pixel.frame_end) begin
               $display("%0t: pixel mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                        oldest_pixel.pixel_word, oldest_pixel.row_end,
                        oldest_pixel.frame_end, rsp_data.pixel_word,
                        rsp_data.row_end, rsp_data.frame_end);
               pixel_errors++;
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_upscale_frame();
      test_single_pixel_frame();
      test_load_wrap_after_shrink();
      test_width_change_mid_frame();
      test_out_of_range_sizes();
      test_random_traffic();
      settle_block();
      $display("%0d commands sent and %0d pixels checked over %0d size settings,",
               items_sent, pixels_checked, size_settings);
      $display("covering up and down scaling, clamped sizes, load wrap and mid-frame resizing");
      if (pixel_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog against a hung handshake
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
